// ----- hw/rtl/ctat_pkg.sv -----
package ctat_pkg;

    // table geometry
    localparam int CAPACITY = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 16;
    localparam int TMO_W    = 16;

    localparam logic [TMO_W-1:0] TIMEOUT_RESET = TMO_W'(1000);

    // command codes
    typedef enum logic [2:0] {
        CMD_ADD     = 3'd0,
        CMD_DELETE  = 3'd1,
        CMD_FIND    = 3'd2,
        CMD_REFRESH = 3'd3,
        CMD_TICK    = 3'd4
    } t_cmd;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_DUP     = 3'd2,
        ST_MISSING = 3'd3,
        ST_EXPIRED = 3'd4,
        ST_DONE    = 3'd5
    } t_status;

    // broadcast control to every cell of the row
    typedef struct packed {
        logic             do_add;
        logic             do_del;
        logic             do_ref;
        logic             do_tick;
        logic             do_shift;
        logic [KEY_W-1:0] key;
        logic [TMO_W-1:0] timeout;
    } t_cell_ctl;

endpackage

// ----- hw/rtl/ctat_cell.sv -----
module ctat_cell
    import ctat_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctl        i_ctl,
    input  logic             i_first_free,
    input  logic             i_pend,
    input  logic [KEY_W-1:0] i_pkey,
    output logic             o_valid,
    output logic             o_match,
    output logic             o_pend,
    output logic [KEY_W-1:0] o_pkey
);

    logic             r_valid;
    logic [KEY_W-1:0] r_key;
    logic [TMO_W-1:0] r_rem;
    logic             r_pend;
    logic [KEY_W-1:0] r_pkey;
    logic             w_take;
    logic             w_expire;

    // key compare and free-slot claim
    assign o_match  = r_valid && (r_key == i_ctl.key);
    assign w_take   = i_ctl.do_add && !r_valid && i_first_free;
    assign w_expire = r_valid && (r_rem <= TMO_W'(1));

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_ctl.do_del && o_match) begin
            r_valid <= 1'b0;
        end else if (i_ctl.do_tick && w_expire) begin
            r_valid <= 1'b0;
        end
    end

    // pending expiry flag, shifted toward slot 0 during the sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (i_ctl.do_tick) begin
            r_pend <= w_expire;
        end else if (i_ctl.do_shift) begin
            r_pend <= i_pend;
        end
    end

    // key, countdown and pending key payload
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_key <= i_ctl.key;
        end
        if (w_take || (i_ctl.do_ref && o_match)) begin
            r_rem <= i_ctl.timeout;
        end else if (i_ctl.do_tick && r_valid) begin
            r_rem <= w_expire ? '0 : r_rem - TMO_W'(1);
        end
        if (i_ctl.do_tick) begin
            r_pkey <= r_key;
        end else if (i_ctl.do_shift) begin
            r_pkey <= i_pkey;
        end
    end

    assign o_valid = r_valid;
    assign o_pend  = r_pend;
    assign o_pkey  = r_pkey;

endmodule

// ----- hw/rtl/ctat_row.sv -----
module ctat_row
    import ctat_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctl        i_ctl,
    output logic             o_any_match,
    output logic             o_head_pend,
    output logic [KEY_W-1:0] o_head_pkey
);

    logic [CAPACITY-1:0] w_valid;
    logic [CAPACITY-1:0] w_match;
    logic [CAPACITY:0]   w_first_free;
    logic [CAPACITY:0]   w_pend;
    logic [KEY_W-1:0]    w_pkey [CAPACITY+1];

    // lowest free slot chain and empty input above the last cell
    assign w_first_free[0]  = 1'b1;
    assign w_pend[CAPACITY] = 1'b0;
    assign w_pkey[CAPACITY] = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign w_first_free[g+1] = w_first_free[g] & w_valid[g];

        ctat_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (i_ctl),
            .i_first_free (w_first_free[g]),
            .i_pend       (w_pend[g+1]),
            .i_pkey       (w_pkey[g+1]),
            .o_valid      (w_valid[g]),
            .o_match      (w_match[g]),
            .o_pend       (w_pend[g]),
            .o_pkey       (w_pkey[g])
        );
    end

    // keys are unique among valid slots, so any hit is the hit
    assign o_any_match = |w_match;
    assign o_head_pend = w_pend[0];
    assign o_head_pkey = w_pkey[0];

endmodule

// ----- hw/rtl/connection_table_with_aging_core.sv -----
// Connection table of CAPACITY keys with per-entry aging countdowns, built as a row of
// cells that each hold one slot. The block takes one command at a time: an item is
// accepted only while the controller is idle. Add, delete, find and refresh register
// their result from the S_CMD state once the output register can take it, the key
// compare running in parallel over all cells, and the next item can be accepted after
// that state. A tick ages every cell in S_TICK, then the expired flags are shifted one
// cell per cycle, unless an expiry at slot 0 waits on a stalled output, through the row
// toward slot 0, which reports them in ascending slot order; a last S_SWEEP step ends the
// sweep and S_DONE registers the closing done result; then the next item is accepted.
// The output register lets a result wait while the next item is accepted.
module connection_table_with_aging_core
    import ctat_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [2:0]       i_command,
    input  logic [KEY_W-1:0] i_conn_key,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [2:0]       o_status,
    output logic [KEY_W-1:0] o_result_key,
    output logic [5:0]       o_occupancy,
    output logic             o_last,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [TMO_W-1:0] i_cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CMD   = 5'b00010,
        S_TICK  = 5'b00100,
        S_SWEEP = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state           r_state, n_state;
    logic [TMO_W-1:0] r_timeout;
    logic [2:0]       r_cmd;
    logic [KEY_W-1:0] r_key;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_sc, n_sc;
    logic             r_ovalid;
    logic [2:0]       r_status;
    logic [KEY_W-1:0] r_rkey;
    logic [CNT_W-1:0] r_occ;
    logic             r_last;

    logic             w_in_xfer;
    logic             w_can_load;
    logic             w_load;
    logic [2:0]       w_status;
    logic [KEY_W-1:0] w_rkey;
    logic             w_rlast;
    logic             w_full;
    logic             w_any_match;
    logic             w_head_pend;
    logic [KEY_W-1:0] w_head_pkey;
    t_cell_ctl        w_ctl;

    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign w_can_load = !r_ovalid || !i_out_stall;
    assign w_full     = (r_count >= CNT_W'(CAPACITY));
    assign o_cfg_ready = 1'b1;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_timeout <= i_cfg_data;
        end
    end

    // latch accepted command
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_cmd <= i_command;
            r_key <= i_conn_key;
        end
    end

    // controller: next state, cell control and result selection
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_sc     = r_sc;
        w_load   = 1'b0;
        w_status = ST_OK;
        w_rkey   = r_key;
        w_rlast  = 1'b1;
        w_ctl    = '{do_add: 1'b0, do_del: 1'b0, do_ref: 1'b0, do_tick: 1'b0,
                     do_shift: 1'b0, key: r_key, timeout: r_timeout};
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    case (i_command)
                        CMD_ADD, CMD_DELETE, CMD_FIND, CMD_REFRESH: n_state = S_CMD;
                        CMD_TICK: n_state = S_TICK;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_CMD: begin
                if (w_can_load) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                    case (r_cmd)
                        CMD_ADD: begin
                            if (w_full) begin
                                w_status = ST_FULL;
                            end else if (w_any_match) begin
                                w_status = ST_DUP;
                            end else begin
                                w_ctl.do_add = 1'b1;
                                n_count      = r_count + CNT_W'(1);
                            end
                        end
                        CMD_DELETE: begin
                            if (w_any_match) begin
                                w_ctl.do_del = 1'b1;
                                n_count      = r_count - CNT_W'(1);
                            end else begin
                                w_status = ST_MISSING;
                            end
                        end
                        CMD_REFRESH: begin
                            w_ctl.do_ref = 1'b1;
                            w_status     = w_any_match ? ST_OK : ST_MISSING;
                        end
                        default: begin
                            w_status = w_any_match ? ST_OK : ST_MISSING;
                        end
                    endcase
                end
            end
            S_TICK: begin
                w_ctl.do_tick = 1'b1;
                n_sc          = '0;
                n_state       = S_SWEEP;
            end
            S_SWEEP: begin
                if (r_sc == CNT_W'(CAPACITY)) begin
                    n_state = S_DONE;
                end else if (!w_head_pend || w_can_load) begin
                    w_ctl.do_shift = 1'b1;
                    n_sc           = r_sc + CNT_W'(1);
                    if (w_head_pend) begin
                        w_load   = 1'b1;
                        w_status = ST_EXPIRED;
                        w_rkey   = w_head_pkey;
                        w_rlast  = 1'b0;
                        n_count  = r_count - CNT_W'(1);
                    end
                end
            end
            S_DONE: begin
                w_status = ST_DONE;
                w_rkey   = '0;
                if (w_can_load) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // controller registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_sc    <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_sc    <= n_sc;
        end
    end

    // row of slot cells
    ctat_row u_row (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .o_any_match (w_any_match),
        .o_head_pend (w_head_pend),
        .o_head_pkey (w_head_pkey)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_status <= w_status;
            r_rkey   <= w_rkey;
            r_occ    <= n_count;
            r_last   <= w_rlast;
        end
    end

    assign o_out_valid  = r_ovalid;
    assign o_status     = r_status;
    assign o_result_key = r_rkey;
    assign o_occupancy  = 6'(r_occ);
    assign o_last       = r_last;

    // occupancy never exceeds the table size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    // sweep position stays within the row
    a_sweep_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> (r_sc <= CNT_W'(CAPACITY)))
        else $error("sweep counter out of range");

    // an accepted tick starts the aging step next cycle
    a_tick_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && i_command == CMD_TICK) |=> (r_state == S_TICK))
        else $error("tick did not start aging");

    // done and single results close the input, expiries do not
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last == (o_status != ST_EXPIRED)))
        else $error("last flag does not match status");

endmodule
